// ----- design/tmcw_pkg.sv -----
// Shared constants, types and state codes for the text-mode console writer.
package tmcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W = $clog2(ROWS + 2);
  localparam int IDX_W = 11;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] ATTR_WHITE_ON_BLACK = 8'h0F;

  localparam int NUM_W = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS = NUM_W / BITS_PER_STEP;
  localparam int STEP_W = $clog2(CONV_STEPS);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic        func;
    logic [7:0]  char_code;
    logic [31:0] number;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
  } in_word_t;

  typedef struct packed {
    logic [10:0] cell_index;
    logic [15:0] cell_value;
    logic        last;
  } out_word_t;

  // One character queued for the cursor side.
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
    logic       last;
  } glyph_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_EMIT
  } front_state_t;

endpackage

// ----- design/text_mode_console_writer.sv -----
// Top level of the text-mode console writer.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_ready  | in_data   (func, char, number, colors)
//   out     | output    | out_valid/out_ready| out_data  (cell index, cell value, last)
//
// A character word goes straight into the queue and its cell leaves through the
// output register. A number word is converted first: the decimal converter shifts
// four bits per cycle, then the ten digit positions are visited in turn from the
// most significant down; a leading zero is dropped, any other digit is queued.
// Reset puts the cursor at row 0, column 0 and empties the queue.
// A stalled output holds the cursor side; the front end keeps converting and
// filling the four-entry queue until it is full.
module text_mode_console_writer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmcw_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tmcw_pkg::out_word_t out_data
);
  import tmcw_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  glyph_t push_data, pop_data;

  tmcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tmcw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tmcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/tmcw_front.sv -----
// Front end: accepts words, converts numbers to decimal, queues characters.
module tmcw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tmcw_pkg::in_word_t in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output tmcw_pkg::glyph_t push_data
);
  import tmcw_pkg::*;

  localparam int DD_W = NUM_DIGITS * 4 + NUM_W;

  // Run BITS_PER_STEP double-dabble iterations on {bcd, binary}.
  function automatic logic [DD_W-1:0] dabble(input logic [DD_W-1:0] v);
    logic [DD_W-1:0] t;
    t = v;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (t[NUM_W + 4*d +: 4] >= 4'd5) begin
          t[NUM_W + 4*d +: 4] = t[NUM_W + 4*d +: 4] + 4'd3;
        end
      end
      t = t << 1;
    end
    return t;
  endfunction

  front_state_t            state_r, state_nxt;
  logic [DD_W-1:0]         dd_r, dd_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [DIGIT_IDX_W-1:0]  idx_r, idx_nxt;
  logic                    started_r, started_nxt;
  logic [3:0]              digit;

  assign digit = dd_r[NUM_W + 4*idx_r +: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      step_r    <= '0;
      idx_r     <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      idx_r     <= idx_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dd_r <= dd_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    dd_nxt      = dd_r;
    step_nxt    = step_r;
    idx_nxt     = idx_r;
    started_nxt = started_r;
    in_ready    = 1'b0;
    push_valid  = 1'b0;
    push_data   = '{ch: in_data.char_code, attr: {in_data.bg_color, in_data.fg_color},
                    last: 1'b1};
    case (state_r)
      F_IDLE: begin
        in_ready = push_ready;
        if (in_valid && !in_data.func) begin
          push_valid = 1'b1;
        end
        if (in_valid && in_data.func && push_ready) begin
          dd_nxt   = {{(NUM_DIGITS*4){1'b0}}, in_data.number};
          step_nxt = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        dd_nxt   = dabble(dd_r);
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CONV_STEPS - 1)) begin
          idx_nxt     = DIGIT_IDX_W'(NUM_DIGITS - 1);
          started_nxt = 1'b0;
          state_nxt   = F_EMIT;
        end
      end
      F_EMIT: begin
        push_data = '{ch: DIGIT_BASE + {4'd0, digit}, attr: ATTR_WHITE_ON_BLACK,
                      last: (idx_r == '0)};
        if (!started_r && digit == 4'd0 && idx_r != '0) begin
          // drop leading zero
          idx_nxt = idx_r - 1'b1;
        end else begin
          push_valid = 1'b1;
          if (push_ready) begin
            started_nxt = 1'b1;
            if (idx_r == '0) begin
              state_nxt = F_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

endmodule

// ----- design/tmcw_fifo.sv -----
// Short character queue between front end and cursor side.
module tmcw_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  tmcw_pkg::glyph_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output tmcw_pkg::glyph_t pop_data
);
  import tmcw_pkg::*;

  glyph_t                    slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(FIFO_DEPTH+1)-1:0] count_r, count_nxt;
  logic                      do_push, do_pop;

  assign push_ready = (count_r != ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? FIFO_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/tmcw_back.sv -----
// Cursor side: wraps the cursor, forms cell writes, holds the output register.
module tmcw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  tmcw_pkg::glyph_t    pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tmcw_pkg::out_word_t out_data
);
  import tmcw_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic             do_pop, is_newline, col_wrap;
  logic [COL_W-1:0] col_w;
  logic [ROW_W-1:0] row_t, row_w;
  logic [IDX_W+ROW_W+COL_W-1:0] idx_full;

  assign pop_ready  = !out_valid_r || out_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign is_newline = (pop_data.ch == NEWLINE_CODE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    col_wrap = (col_r >= COL_W'(COLUMNS));
    col_w    = col_wrap ? '0 : col_r;
    row_t    = col_wrap ? ROW_W'(row_r + 1'b1) : row_r;
    row_w    = (row_t >= ROW_W'(ROWS)) ? '0 : row_t;
    idx_full = (IDX_W+ROW_W+COL_W)'(row_w) * (IDX_W+ROW_W+COL_W)'(COLUMNS)
               + (IDX_W+ROW_W+COL_W)'(col_w);

    col_nxt       = col_r;
    row_nxt       = row_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (do_pop) begin
      if (is_newline) begin
        col_nxt = '0;
        if (row_r < ROW_W'(ROWS)) begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt       = col_w + 1'b1;
        row_nxt       = row_w;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{cell_index: idx_full[IDX_W-1:0],
                          cell_value: {pop_data.attr, pop_data.ch},
                          last: pop_data.last};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
